>>> design/tds_pkg.sv
package tds_pkg;

  // default sizes of the solver
  localparam int MAX_ROWS_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  // one row of the system
  typedef struct packed {
    logic signed [31:0] sub_coef;
    logic signed [31:0] main_coef;
    logic signed [31:0] super_coef;
    logic signed [31:0] rhs_value;
    logic               final_row;
  } in_item_t;

  // one solution component
  typedef struct packed {
    logic signed [31:0] solution_value;
    logic [5:0]         row_index;
    logic               final_value;
    logic               singular;
  } out_item_t;

  // arithmetic operations of the shared engine
  typedef enum logic [2:0] {
    OP_PIV,
    OP_NUM,
    OP_RECIP,
    OP_UPPER,
    OP_RHS,
    OP_BACK
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    op_e  op;
    logic idx_init;
    logic idx_clr;
    logic idx_dec;
    logic idx_inc;
    logic emit;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic last;
    logic row_zero;
    logic idx_zero;
    logic idx_at_row;
    logic out_free;
  } dp_sts_t;

endpackage

>>> design/tds_ram.sv
module tds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/tds_dp.sv
module tds_dp import tds_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CH   = 16;
  localparam int NCH  = (DW + CH - 1) / CH;
  localparam int MBW  = NCH * CH;
  localparam int PW   = MBW + DW;
  localparam int SW   = (PW > FRAC_BITS + 2) ? PW : FRAC_BITS + 2;
  localparam int QW   = FRAC_BITS + 1;
  localparam int CMAX = (NCH > QW) ? NCH : QW;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int EW   = (DW > 32) ? DW : 32;

  localparam logic [DW-1:0] MAX_S = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_S = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [EW-1:0] I_MAX = signed'(EW'(MAX_S));
  localparam logic signed [EW-1:0] I_MIN = EW'(signed'(MIN_S));
  localparam logic signed [EW-1:0] O_MAX = EW'(signed'(32'h7fffffff));
  localparam logic signed [EW-1:0] O_MIN = EW'(signed'(32'h80000000));

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DW-1:0] sat_mag(input logic neg, input logic [SW-1:0] m);
    logic [DW-1:0] lo;
    lo = m[DW-1:0];
    if (m > SW'(MAX_S)) return neg ? MIN_S : MAX_S;
    return neg ? (~lo + 1'b1) : lo;
  endfunction

  function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] d;
    d = {a[DW-1], a} - {b[DW-1], b};
    if (d[DW] != d[DW-1]) return d[DW] ? MIN_S : MAX_S;
    return d[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] clamp_in(input logic [31:0] v);
    logic signed [EW-1:0] w;
    w = EW'(signed'(v));
    if (w > I_MAX) return MAX_S;
    if (w < I_MIN) return MIN_S;
    return DW'(w);
  endfunction

  function automatic logic [31:0] clamp_out(input logic [DW-1:0] v);
    logic signed [EW-1:0] w;
    w = EW'(signed'(v));
    if (w > O_MAX) return 32'h7fffffff;
    if (w < O_MIN) return 32'h80000000;
    return 32'(w);
  endfunction

  // row registers
  logic [DW-1:0] sub_q, dia_q, sup_q, rhs_q;
  logic          last_q;
  // sweep values
  logic [DW-1:0] pmu_q, pmr_q, piv_q, num_q, m_q, cm_q, x_q;
  logic          zps_q;
  logic [RW-1:0] row_q, idx_q;
  // shared engine
  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] ma_q, rem_q, dv_q;
  logic [MBW-1:0] mb_q;
  logic [PW-1:0] acc_q;
  logic          neg_q;
  logic [QW-1:0] quo_q;
  // output register
  logic          out_valid_q;
  out_item_t     out_q;

  logic [DW-1:0] up_rd, rhs_rd;
  logic [DW-1:0] opa, opb;
  logic [DW+CH-1:0] psum;
  logic [PW-1:0] acc_step;
  logic          bit_in, ge;
  logic [DW:0]   rsh, rsub;
  logic [DW-1:0] prod, recip, xnew;
  logic          done, piv_zero, last_in;
  logic          up_we, rhs_we;
  logic [RW-1:0] rhs_waddr;
  logic [DW-1:0] rhs_wdata;

  assign piv_zero = (piv_q == '0);
  assign done     = busy_q && (cnt_q == '0);
  assign last_in  = in_item_i.final_row || (row_q == RW'(MAX_ROWS - 1));

  // operand selection at start
  always_comb begin
    case (cmd_i.op)
      OP_PIV:   begin opa = sub_q; opb = pmu_q; end
      OP_NUM:   begin opa = sub_q; opb = pmr_q; end
      OP_UPPER: begin opa = sup_q; opb = m_q;   end
      OP_RHS:   begin opa = num_q; opb = m_q;   end
      OP_BACK:  begin opa = up_rd; opb = x_q;   end
      default:  begin opa = piv_q; opb = piv_q; end
    endcase
  end

  // multiply step: one 16-bit slice of the multiplier magnitude per cycle
  assign psum     = ma_q * mb_q[MBW-1 -: CH];
  assign acc_step = (acc_q << CH) + PW'(psum);

  // restoring divide step for the reciprocal
  assign bit_in = (cnt_q == CW'(QW));
  assign rsh    = {rem_q, bit_in};
  assign ge     = (rsh >= {1'b0, dv_q});
  assign rsub   = rsh - {1'b0, dv_q};

  // finished results
  assign prod  = sat_mag(neg_q, SW'(acc_q) >> FRAC_BITS);
  assign recip = sat_mag(piv_q[DW-1], SW'(quo_q));
  assign xnew  = sat_sub(rhs_rd, prod);

  // engine and sweep control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      pmu_q       <= '0;
      pmr_q       <= '0;
      zps_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (cmd_i.op == OP_RECIP) ? CW'(QW) : CW'(NCH);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
      if (done && cmd_i.op == OP_RECIP) begin
        zps_q <= zps_q | piv_zero;
      end
      if (done && cmd_i.op == OP_RHS) begin
        pmu_q <= cm_q;
        pmr_q <= prod;
        if (!last_q) begin
          row_q <= row_q + 1'b1;
        end
      end
      if (cmd_i.idx_init) begin
        idx_q <= row_q - 1'b1;
      end else if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_q - 1'b1;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.finish) begin
        row_q <= '0;
        pmu_q <= '0;
        pmr_q <= '0;
        zps_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sub_q  <= clamp_in(in_item_i.sub_coef);
      dia_q  <= clamp_in(in_item_i.main_coef);
      sup_q  <= last_in ? '0 : clamp_in(in_item_i.super_coef);
      rhs_q  <= clamp_in(in_item_i.rhs_value);
      last_q <= last_in;
    end
    if (cmd_i.start) begin
      ma_q  <= mag_of(opa);
      mb_q  <= MBW'(mag_of(opb));
      neg_q <= opa[DW-1] ^ opb[DW-1];
      acc_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      dv_q  <= mag_of(piv_q);
    end else if (busy_q && cnt_q != '0) begin
      acc_q <= acc_step;
      mb_q  <= mb_q << CH;
      if (ge) begin
        rem_q <= rsub[DW-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rsh[DW-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
    if (done) begin
      case (cmd_i.op)
        OP_PIV:   piv_q <= sat_sub(dia_q, prod);
        OP_NUM:   num_q <= sat_sub(rhs_q, prod);
        OP_RECIP: m_q   <= piv_zero ? '0 : recip;
        OP_UPPER: cm_q  <= prod;
        OP_RHS:   x_q   <= prod;
        OP_BACK:  x_q   <= xnew;
        default:  ;
      endcase
    end
    if (cmd_i.emit) begin
      out_q.solution_value <= clamp_out(rhs_rd);
      out_q.row_index      <= 6'(idx_q);
      out_q.final_value    <= (idx_q == row_q);
      out_q.singular       <= zps_q;
    end
  end

  // coefficient stores
  assign up_we     = done && (cmd_i.op == OP_RHS);
  assign rhs_we    = done && (cmd_i.op == OP_RHS || cmd_i.op == OP_BACK);
  assign rhs_waddr = (cmd_i.op == OP_BACK) ? idx_q : row_q;
  assign rhs_wdata = (cmd_i.op == OP_BACK) ? xnew : prod;

  tds_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (row_q),
    .wdata_i (cm_q),
    .raddr_i (idx_q),
    .rdata_o (up_rd)
  );

  tds_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (rhs_we),
    .waddr_i (rhs_waddr),
    .wdata_i (rhs_wdata),
    .raddr_i (idx_q),
    .rdata_o (rhs_rd)
  );

  // status
  assign sts_o.done       = done;
  assign sts_o.last       = last_q;
  assign sts_o.row_zero   = (row_q == '0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.idx_at_row = (idx_q == row_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> design/tds_ctrl.sv
module tds_ctrl import tds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PIV   = 4'd1;
  localparam logic [3:0] ST_NUM   = 4'd2;
  localparam logic [3:0] ST_RECIP = 4'd3;
  localparam logic [3:0] ST_UPPER = 4'd4;
  localparam logic [3:0] ST_RHS   = 4'd5;
  localparam logic [3:0] ST_BREAD = 4'd6;
  localparam logic [3:0] ST_BACK  = 4'd7;
  localparam logic [3:0] ST_EREAD = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       start_q, start_d;

  // sequencing of one row and of the back substitution
  always_comb begin
    state_d      = state_q;
    start_d      = 1'b0;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.start  = start_q;
    cmd_o.op     = OP_PIV;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PIV;
          start_d    = 1'b1;
        end
      end
      ST_PIV: begin
        cmd_o.op = OP_PIV;
        if (sts_i.done) begin
          state_d = ST_NUM;
          start_d = 1'b1;
        end
      end
      ST_NUM: begin
        cmd_o.op = OP_NUM;
        if (sts_i.done) begin
          state_d = ST_RECIP;
          start_d = 1'b1;
        end
      end
      ST_RECIP: begin
        cmd_o.op = OP_RECIP;
        if (sts_i.done) begin
          state_d = ST_UPPER;
          start_d = 1'b1;
        end
      end
      ST_UPPER: begin
        cmd_o.op = OP_UPPER;
        if (sts_i.done) begin
          state_d = ST_RHS;
          start_d = 1'b1;
        end
      end
      ST_RHS: begin
        cmd_o.op = OP_RHS;
        if (sts_i.done) begin
          if (!sts_i.last) begin
            state_d = ST_IDLE;
          end else if (sts_i.row_zero) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_EREAD;
          end else begin
            cmd_o.idx_init = 1'b1;
            state_d        = ST_BREAD;
          end
        end
      end
      ST_BREAD: begin
        cmd_o.op = OP_BACK;
        state_d  = ST_BACK;
        start_d  = 1'b1;
      end
      ST_BACK: begin
        cmd_o.op = OP_BACK;
        if (sts_i.done) begin
          if (sts_i.idx_zero) begin
            state_d = ST_EREAD;
          end else begin
            cmd_o.idx_dec = 1'b1;
            state_d       = ST_BREAD;
          end
        end
      end
      ST_EREAD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_at_row) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_EREAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
    end
  end

endmodule

>>> design/tridiagonal_solver.sv
// forward step: each row item runs the pivot, numerator, reciprocal, upper and rhs operations
// in turn on the shared multiply/divide engine (one bit per cycle divide)
// back substitution: one engine multiply per row below the last row, down to row 0
// each result passes ST_EREAD, then ST_EMIT; new rows wait until the last result is loaded
// reset: asynchronous, active low; clears the row count, pivot flag and handshake state,
// the coefficient stores are not cleared
module tridiagonal_solver import tds_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  tds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and stores
  tds_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // engine never completes while waiting for a row
  assert property (@(posedge clk_i) disable iff (!rst_ni) sts.done |-> !in_ready_o)
    else $error("engine done while idle");

  // a result is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> sts.out_free)
    else $error("output register overwritten");

  // every accepted row starts the engine next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.load |=> cmd.start)
    else $error("row accepted without engine start");

  // a system only ends with its last result
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.finish |-> cmd.emit)
    else $error("system finished without result");

endmodule

>>> tb/tb_top.sv
module tb_top import tds_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = MAX_ROWS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  tridiagonal_solver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // solver state mirrored by the testbench
  longint    upper_st[ROWS];
  longint    rhs_st[ROWS];
  int        rows_seen;
  longint    last_upper;
  longint    last_rhs;
  bit        pivot_zero;
  out_item_t solution_q[$];

  int  err_cnt;
  int  systems_done;
  int  comps_checked;
  int  singular_systems;
  bit  quiet;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run time limit
  initial begin
    #5ms;
    $display("timeout at %0t", $time);
    $display("FAILURE");
    $finish;
  end

  function automatic longint sat(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    longint mag;
    p = a * b;
    mag = (p < 0) ? -p : p;
    mag = mag >>> FRAC;
    return sat((p < 0) ? -mag : mag);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return sat(a - b);
  endfunction

  function automatic longint qrecip(longint p);
    longint mag;
    longint q;
    mag = (p < 0) ? -p : p;
    q = ONE / mag;
    return sat((p < 0) ? -q : q);
  endfunction

  // forward step of one row; on the last row back substitution and queueing
  function automatic void sweep_row(in_item_t it);
    longint sub_v;
    longint dia_v;
    longint sup_v;
    longint rhs_v;
    longint piv;
    longint num;
    longint m;
    longint x;
    int     row;
    bit     last;
    out_item_t r;
    sub_v = it.sub_coef;
    dia_v = it.main_coef;
    sup_v = it.super_coef;
    rhs_v = it.rhs_value;
    row = rows_seen;
    last = it.final_row || (row >= ROWS - 1);
    if (last) sup_v = 0;
    if (row == 0) begin
      piv = dia_v;
      num = rhs_v;
    end else begin
      piv = qsub(dia_v, qmul(sub_v, last_upper));
      num = qsub(rhs_v, qmul(sub_v, last_rhs));
    end
    if (piv == 0) begin
      pivot_zero = 1'b1;
      m = 0;
    end else begin
      m = qrecip(piv);
    end
    upper_st[row] = qmul(sup_v, m);
    rhs_st[row] = qmul(num, m);
    last_upper = upper_st[row];
    last_rhs = rhs_st[row];
    if (!last) begin
      rows_seen = row + 1;
      return;
    end
    // back substitution
    x = rhs_st[row];
    for (int k = row - 1; k >= 0; k--) begin
      x = qsub(rhs_st[k], qmul(upper_st[k], x));
      rhs_st[k] = x;
    end
    for (int k = 0; k <= row; k++) begin
      r.solution_value = rhs_st[k][31:0];
      r.row_index = k[5:0];
      r.final_value = (k == row);
      r.singular = pivot_zero;
      solution_q.insert(solution_q.size(), r);
    end
    systems_done++;
    if (pivot_zero) singular_systems++;
    rows_seen = 0;
    last_upper = 0;
    last_rhs = 0;
    pivot_zero = 1'b0;
  endfunction

  function automatic in_item_t mk_row(logic [31:0] s, logic [31:0] d, logic [31:0] u,
                                      logic [31:0] b, logic fin);
    in_item_t it;
    it.sub_coef = s;
    it.main_coef = d;
    it.super_coef = u;
    it.rhs_value = b;
    it.final_row = fin;
    return it;
  endfunction

  // send one row item and update the prediction once it is taken
  task automatic send_row(in_item_t it);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sweep_row(it);
  endtask

  // result sink with random stalls
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 27);
  end

  // compare each result item with the oldest predicted component
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_item_o);
        err_cnt++;
      end else begin
        exp_r = solution_q.pop_front();
        comps_checked++;
        if (out_item_o.solution_value !== exp_r.solution_value) begin
          $display("%0t: solution_value exp %h got %h", $time,
                   exp_r.solution_value, out_item_o.solution_value);
          err_cnt++;
        end
        if (out_item_o.row_index !== exp_r.row_index) begin
          $display("%0t: row_index exp %0d got %0d", $time,
                   exp_r.row_index, out_item_o.row_index);
          err_cnt++;
        end
        if (out_item_o.final_value !== exp_r.final_value) begin
          $display("%0t: final_value exp %b got %b", $time,
                   exp_r.final_value, out_item_o.final_value);
          err_cnt++;
        end
        if (out_item_o.singular !== exp_r.singular) begin
          $display("%0t: singular exp %b got %b", $time,
                   exp_r.singular, out_item_o.singular);
          err_cnt++;
        end
      end
    end
  end

  // random well conditioned coefficient in +-span units of one
  function automatic logic [31:0] rnd_fix(int span);
    longint v;
    v = longint'($urandom_range(0, span * 2 * 4096)) * 4096 - longint'(span) * ONE;
    return v[31:0];
  endfunction

  task automatic send_random_system(int len, bit noisy);
    logic [31:0] d;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        send_row(mk_row($urandom, $urandom, $urandom, $urandom, i == len - 1));
      end else begin
        d = rnd_fix(2);
        d = d[31] ? d - 32'(3 * ONE) : d + 32'(3 * ONE);
        send_row(mk_row(rnd_fix(1), d, rnd_fix(1), rnd_fix(4), i == len - 1));
      end
    end
  endtask

  // one row systems and a small hand made system
  task automatic test_basic();
    send_row(mk_row(32'h0, 32'(ONE), 32'h0, 32'(2 * ONE), 1'b1));
    send_row(mk_row(32'h1234, 32'(-2 * ONE), 32'h5555, 32'(3 * ONE), 1'b1));
    send_row(mk_row(32'h0, 32'(4 * ONE), 32'(ONE), 32'(5 * ONE), 1'b0));
    send_row(mk_row(32'(ONE), 32'(4 * ONE), 32'(ONE), 32'(6 * ONE), 1'b0));
    send_row(mk_row(32'(ONE), 32'(4 * ONE), 32'h7fffffff, 32'(5 * ONE), 1'b1));
  endtask

  // field extremes, saturation of products and reciprocals
  task automatic test_extremes();
    send_row(mk_row(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0));
    send_row(mk_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b0));
    send_row(mk_row(32'h7fffffff, 32'h00000001, 32'hffffffff, 32'h7fffffff, 1'b1));
    send_row(mk_row(32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h80000000, 1'b0));
    send_row(mk_row(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1));
  endtask

  // zero pivot on the first row and later in the sweep
  task automatic test_zero_pivot();
    send_row(mk_row(32'h0, 32'h0, 32'(ONE), 32'(ONE), 1'b1));
    send_row(mk_row(32'h0, 32'(ONE), 32'(ONE), 32'(ONE), 1'b0));
    send_row(mk_row(32'(ONE), 32'(ONE), 32'(ONE), 32'(2 * ONE), 1'b0));
    send_row(mk_row(32'(ONE), 32'(3 * ONE), 32'h0, 32'(ONE), 1'b1));
    // next system must start clean
    send_row(mk_row(32'h0, 32'(2 * ONE), 32'h0, 32'(ONE), 1'b1));
  endtask

  // system longer than the store: the last slot ends it
  task automatic test_long_system();
    send_random_system(ROWS + 1, 1'b0);
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    quiet = 1'b1;
    while (sent < 250) begin
      if (sent >= 60) quiet = 1'b0;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, ROWS) : $urandom_range(1, 8);
      send_random_system(len, $urandom_range(0, 99) < 20);
      sent += len;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    quiet = 1'b0;
    err_cnt = 0;
    systems_done = 0;
    comps_checked = 0;
    singular_systems = 0;
    rows_seen = 0;
    last_upper = 0;
    last_rhs = 0;
    pivot_zero = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic();
    test_extremes();
    test_zero_pivot();
    test_long_system();
    test_random();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    quiet = 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("covered %0d systems (%0d singular), %0d solution items checked",
             systems_done, singular_systems, comps_checked);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
